### rtl/prefix_expression_stack_evaluator_top_assert.svh
// assertion macros for the checker of the stack evaluator
`ifndef PREFIX_EXPRESSION_STACK_EVALUATOR_TOP_ASSERT_SVH
`define PREFIX_EXPRESSION_STACK_EVALUATOR_TOP_ASSERT_SVH

// consequent must hold on the next clock edge, masked while reset is high
`define PESE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stack evaluator check failed");

// consequent must hold on the same clock edge, masked while reset is high
`define PESE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stack evaluator check failed");

// consequent must hold on the next clock edge, also across reset
`define PESE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("stack evaluator check failed");

`endif

### rtl/pese_pkg.sv
// package of widths, opcodes, status codes and shared types for the stack evaluator
`timescale 1ns / 1ps
`default_nettype none
package pese_pkg;

   localparam int DATA_W   = 32;
   localparam int NUM_W    = 31;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;

   // token opcodes
   localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
   localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
   localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
   localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
   localparam logic [OP_W-1:0] OP_REM  = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ILLEGAL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DIVZERO  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

   // sequencer to arithmetic unit
   typedef struct packed {
      logic            start;
      logic [OP_W-1:0] op;
   } alu_req_type;

   // arithmetic unit to sequencer
   typedef struct packed {
      logic done;
   } alu_rsp_type;

endpackage
`default_nettype wire

### rtl/pese_if.sv
// valid/ready channel interfaces for tokens and results
`timescale 1ns / 1ps
`default_nettype none
interface pese_req_if;
   import pese_pkg::*;

   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  opcode;
   logic [NUM_W-1:0] number_value;
   logic             last_token;

   modport source (output valid, output opcode, output number_value, output last_token,
                   input ready);
   modport sink   (input valid, input opcode, input number_value, input last_token,
                   output ready);
   modport monitor (input valid, input ready, input opcode, input number_value,
                    input last_token);
endinterface

interface pese_rsp_if;
   import pese_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result_value;
   logic [STATUS_W-1:0]      status;

   modport source (output valid, output result_value, output status, input ready);
   modport sink   (input valid, input result_value, input status, output ready);
   modport monitor (input valid, input ready, input result_value, input status);
endinterface
`default_nettype wire

### rtl/pese_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module pese_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/pese_alu.sv
// shared arithmetic unit: add, subtract, multiply and a radix-2 divider
`timescale 1ns / 1ps
`default_nettype none
module pese_alu (
   input  logic                       clock,
   input  logic                       reset,
   input  pese_pkg::alu_req_type      req_ctl,
   input  logic [pese_pkg::DATA_W-1:0] a,
   input  logic [pese_pkg::DATA_W-1:0] b,
   output pese_pkg::alu_rsp_type      rsp_ctl,
   output logic [pese_pkg::DATA_W-1:0] result
);
   import pese_pkg::*;

   localparam int STEP_W = $clog2(DATA_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

   typedef enum logic [2:0] {
      ALU_IDLE = 3'b001,
      ALU_DIV  = 3'b010,
      ALU_FIX  = 3'b100
   } alu_state_type;

   alu_state_type       state_ff, state_in;
   logic                done_ff, done_in;
   logic [DATA_W-1:0]   result_ff, result_in;
   logic [DATA_W-1:0]   rem_ff, rem_in;
   logic [DATA_W-1:0]   quo_ff, quo_in;
   logic [DATA_W-1:0]   mb_ff, mb_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                neg_q_ff, neg_q_in;
   logic                neg_r_ff, neg_r_in;
   logic                is_rem_ff, is_rem_in;

   logic [DATA_W-1:0]   mag_a;
   logic [DATA_W-1:0]   mag_b;
   logic [DATA_W-1:0]   product;
   logic [DATA_W:0]     shifted;
   logic [DATA_W:0]     trial;

   // operand magnitudes, wrapped product and one restoring step
   always_comb begin
      mag_a   = a[DATA_W-1] ? (DATA_W'(0) - a) : a;
      mag_b   = b[DATA_W-1] ? (DATA_W'(0) - b) : b;
      product = a * b;
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      trial   = shifted - {1'b0, mb_ff};
   end

   // sequencing of the unit
   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      mb_in     = mb_ff;
      step_in   = step_ff;
      neg_q_in  = neg_q_ff;
      neg_r_in  = neg_r_ff;
      is_rem_in = is_rem_ff;
      unique case (state_ff)
         ALU_IDLE: begin
            if (req_ctl.start) begin
               unique case (req_ctl.op) inside
                  OP_ADD: begin
                     result_in = a + b;
                     done_in   = 1'b1;
                  end
                  OP_SUB: begin
                     result_in = a - b;
                     done_in   = 1'b1;
                  end
                  OP_MUL: begin
                     result_in = product;
                     done_in   = 1'b1;
                  end
                  OP_DIV, OP_REM: begin
                     rem_in    = '0;
                     quo_in    = mag_a;
                     mb_in     = mag_b;
                     step_in   = '0;
                     neg_q_in  = a[DATA_W-1] ^ b[DATA_W-1];
                     neg_r_in  = a[DATA_W-1];
                     is_rem_in = (req_ctl.op == OP_REM);
                     state_in  = ALU_DIV;
                  end
                  default: begin
                     result_in = '0;
                     done_in   = 1'b1;
                  end
               endcase
            end
         end
         ALU_DIV: begin
            // one quotient bit a cycle, most significant first
            if (!trial[DATA_W]) begin
               rem_in = trial[DATA_W-1:0];
               quo_in = {quo_ff[DATA_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[DATA_W-1:0];
               quo_in = {quo_ff[DATA_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ALU_FIX;
            end
         end
         ALU_FIX: begin
            // restore the signs of quotient and remainder
            if (is_rem_ff) begin
               result_in = neg_r_ff ? (DATA_W'(0) - rem_ff) : rem_ff;
            end else begin
               result_in = neg_q_ff ? (DATA_W'(0) - quo_ff) : quo_ff;
            end
            done_in  = 1'b1;
            state_in = ALU_IDLE;
         end
         default: begin
            state_in = ALU_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ALU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      result_ff <= result_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      mb_ff     <= mb_in;
      step_ff   <= step_in;
      neg_q_ff  <= neg_q_in;
      neg_r_ff  <= neg_r_in;
      is_rem_ff <= is_rem_in;
   end

   assign rsp_ctl.done = done_ff;
   assign result       = result_ff;

endmodule
`default_nettype wire

### rtl/prefix_expression_stack_evaluator_top.sv
// Prefix expression evaluator: token sequencer around an operand stack ram and
// a shared arithmetic unit.
//
// Tokens enter on req, rightmost first, one beat per token; the beat flagged
// last_token closes the expression. A number is pushed, an operator pops a
// (top) then b and pushes a op b with 32-bit wrap. Only the closing token
// makes a result beat on rsp: the top of stack with ok status, or zero with
// the first error of the expression. Stack and status then clear.
// The block takes one token at a time and holds req.ready low while it works.
// A number or unknown opcode goes from decode to finish; add, subtract,
// multiply, divide or remainder first read b from the ram and then wait on
// the arithmetic unit, where the 32-step radix-2 divider sets the worst case.
// A divide by zero skips the unit, and any token after an error goes from
// decode to finish. The result beat is registered in the finish state and
// sits in an output register until rsp.ready.
// A stalled result does not stop the next tokens; only a further closing
// token waits for the output register to empty.
// Synchronous reset empties the stack, clears the status and drops rsp.valid;
// the stack ram needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module prefix_expression_stack_evaluator_top #(
   parameter int STACK_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   pese_req_if.sink    req,
   pese_rsp_if.source  rsp
);
   import pese_pkg::*;

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   typedef enum logic [4:0] {
      SEQ_IDLE   = 5'b00001,
      SEQ_DECODE = 5'b00010,
      SEQ_READ   = 5'b00100,
      SEQ_CALC   = 5'b01000,
      SEQ_FINISH = 5'b10000
   } seq_state_type;

   seq_state_type         state_ff, state_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic                  last_ff, last_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [STATUS_W-1:0]   err_ff, err_in;
   logic [DATA_W-1:0]     top_ff, top_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic [CNT_W-1:0]      count_m2;
   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [DATA_W-1:0]     ram_wr_data;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [DATA_W-1:0]     ram_rd_data;

   alu_req_type           alu_req;
   alu_rsp_type           alu_rsp;
   logic [DATA_W-1:0]     alu_result;

   // operand stack storage
   pese_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // shared arithmetic unit, a comes from the top register, b from the ram
   pese_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .req_ctl (alu_req),
      .a       (top_ff),
      .b       (ram_rd_data),
      .rsp_ctl (alu_rsp),
      .result  (alu_result)
   );

   assign count_m2 = count_ff - CNT_W'(2);

   // token sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      num_in        = num_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      top_in        = top_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = count_ff[ADDR_W-1:0];
      ram_wr_data   = top_in;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = count_m2[ADDR_W-1:0];
      alu_req.start = 1'b0;
      alu_req.op    = op_ff;

      // result beat taken by the receiver
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         SEQ_IDLE: begin
            if (req.valid) begin
               op_in    = req.opcode;
               num_in   = req.number_value;
               last_in  = req.last_token;
               state_in = SEQ_DECODE;
            end
         end
         SEQ_DECODE: begin
            state_in = SEQ_FINISH;
            if (err_ff == STATUS_OK) begin
               unique case (op_ff) inside
                  OP_PUSH: begin
                     if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                        err_in = STATUS_OVERFLOW;
                     end else begin
                        top_in      = DATA_W'(num_ff);
                        ram_wr_en   = 1'b1;
                        ram_wr_data = DATA_W'(num_ff);
                        count_in    = count_ff + 1'b1;
                     end
                  end
                  OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM: begin
                     if (count_ff < CNT_W'(2)) begin
                        err_in = STATUS_ILLEGAL;
                     end else begin
                        ram_rd_en = 1'b1;
                        state_in  = SEQ_READ;
                     end
                  end
                  default: begin
                     state_in = SEQ_FINISH;
                  end
               endcase
            end
         end
         SEQ_READ: begin
            // b is now out of the ram
            if (((op_ff == OP_DIV) || (op_ff == OP_REM)) && (ram_rd_data == '0)) begin
               err_in   = STATUS_DIVZERO;
               count_in = count_m2;
               state_in = SEQ_FINISH;
            end else begin
               alu_req.start = 1'b1;
               state_in      = SEQ_CALC;
            end
         end
         SEQ_CALC: begin
            // the result replaces b, one entry fewer
            if (alu_rsp.done) begin
               top_in      = alu_result;
               ram_wr_en   = 1'b1;
               ram_wr_addr = count_m2[ADDR_W-1:0];
               ram_wr_data = alu_result;
               count_in    = count_ff - 1'b1;
               state_in    = SEQ_FINISH;
            end
         end
         SEQ_FINISH: begin
            if (!last_ff) begin
               state_in = SEQ_IDLE;
            end else if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               if (err_ff != STATUS_OK) begin
                  rsp_value_in  = '0;
                  rsp_status_in = err_ff;
               end else if (count_ff == '0) begin
                  rsp_value_in  = '0;
                  rsp_status_in = STATUS_ILLEGAL;
               end else begin
                  rsp_value_in  = top_ff;
                  rsp_status_in = STATUS_OK;
               end
               count_in = '0;
               err_in   = STATUS_OK;
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         err_ff       <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      num_ff        <= num_in;
      last_ff       <= last_in;
      top_ff        <= top_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req.ready        = (state_ff == SEQ_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_value = $signed(rsp_value_ff);
   assign rsp.status       = rsp_status_ff;

endmodule
`default_nettype wire

### rtl/pese_checker.sv
// port-level checker for the stack evaluator and its bind to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "prefix_expression_stack_evaluator_top_assert.svh"
module pese_checker (
   input logic        clock,
   input logic        reset,
   pese_req_if.sink   req,
   pese_rsp_if.source rsp
);
   import pese_pkg::*;

   // reset drops any pending result beat
   `PESE_ASSERT_NEXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp.valid)

   // one token at a time: no beat taken right after an accepted one
   `PESE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req.valid && req.ready, !req.ready)

   // error results carry a zero value
   `PESE_ASSERT_SAME(a_error_value_zero, clock, reset, rsp.valid && (rsp.status != STATUS_OK), rsp.result_value == '0)

   // a stalled result beat holds
   `PESE_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.result_value) && $stable(rsp.status))

endmodule

bind prefix_expression_stack_evaluator_top pese_checker u_pese_checker (
   .clock (clock),
   .reset (reset),
   .req   (req),
   .rsp   (rsp)
);
`default_nettype wire
